// ===== hw/rtl/lcoin_pkg.sv =====
// Shared widths, register codes and helpers for the lattice coincidence tester.
// Used by lattice_coincidence_test; depends on nothing else.
`default_nettype none

package lcoin_pkg;

    // Item fields
    localparam int IDX_W      = 4;
    localparam int TRIG_W     = 18;
    localparam int INDEX_BOUND = 8;
    localparam int S_TDATA_W  = 56;   // 4 x 4 + 2 x 18 = 52 bits, padded to bytes
    localparam int M_TDATA_W  = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TOL_W      = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

    // Datapath widths
    localparam int LAT_W      = 32;                  // one Q16.16 component
    localparam int ROT_PROD_W = LAT_W + TRIG_W;      // component x trig, Q.32
    localparam int ROT_SUM_W  = ROT_PROD_W + 1;
    localparam int FRAC_W     = 16;
    localparam int ROT_W      = ROT_SUM_W - FRAC_W;  // rounded rotated component
    localparam int A_PROD_W   = LAT_W + IDX_W;
    localparam int COORD_W    = 40;                  // lattice point coordinate
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = 40;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PART_W     = 2 * HALF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int NORM_W     = SQ_W + 1;
    localparam int CHUNK_W    = NORM_W / 3;
    localparam int TSQ_W      = 2 * TOL_W;
    localparam int CPROD_W    = CHUNK_W + TSQ_W;
    localparam int RHS_W      = CPROD_W + 2 * CHUNK_W;
    localparam int N_MAG      = 6;                   // xa, ya, xb, yb, dx, dy
    localparam int N_STAGE    = 10;

    localparam logic signed [ROT_SUM_W-1:0] ROUND_HALF = ROT_SUM_W'(32768);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LAT_A_FIRST  = 3'd0,
        CFG_LAT_A_SECOND = 3'd1,
        CFG_LAT_B_FIRST  = 3'd2,
        CFG_LAT_B_SECOND = 3'd3,
        CFG_MATCH_TOL    = 3'd4
    } cfg_reg_t;

    function automatic logic index_ok(input logic signed [IDX_W-1:0] i);
        int v;
        v = int'(i);
        return (v >= -INDEX_BOUND) && (v <= INDEX_BOUND - 1);
    endfunction

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] u;
        u = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return u[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lattice_coincidence_test.sv =====
// Lattice coincidence tester: one candidate coincidence of two 2D lattices per item.
// Depends on lcoin_pkg.
//
// Input channel s_*: one item carries the four integer multiples m1, m2, n1, n2 and
// the cosine and sine of the twist angle. Result channel m_*: one item per input
// item, is_match in bit 0. The user must set the lattice vectors and tolerance on
// the cfg_* write port while no item is in flight; the block does not enforce it.
// The datapath is a ten-stage pipeline: rotate B (products, then sum and round),
// form the lattice points, take magnitudes, square in split partial products, pick
// the smaller norm, scale it by tolerance squared in three chunks, then compare.
// Throughput is one item per cycle while the output does not stall, set by the
// pipeline advancing as a whole.
// When m_tvalid is high and m_tready low the whole pipeline holds and s_tready
// drops; nothing is lost or repeated. Reset clears all valid bits, sets the
// lattice registers to zero and the tolerance to 655 (about 0.01).
`default_nettype none

module lattice_coincidence_test (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // cfg port
    input  wire logic                             cfg_we,
    input  wire logic [lcoin_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lcoin_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // s_tdata: a_index_one[3:0], a_index_two[7:4], b_index_one[11:8],
    //          b_index_two[15:12], cos_angle[33:16], sin_angle[51:34], zero[55:52]
    input  wire logic [lcoin_pkg::S_TDATA_W-1:0]  s_tdata,
    // result items
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: is_match[0], zero[7:1]
    output      logic [lcoin_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lcoin_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CFG_DATA_W-1:0] lat_a_first_reg, lat_a_second_reg;
    logic [CFG_DATA_W-1:0] lat_b_first_reg, lat_b_second_reg;
    logic [TOL_W-1:0]      tol_reg;
    logic [TSQ_W-1:0]      tol_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_a_first_reg  <= '0;
            lat_a_second_reg <= '0;
            lat_b_first_reg  <= '0;
            lat_b_second_reg <= '0;
            tol_reg          <= TOL_RESET;
            tol_sq_reg       <= TSQ_W'(TOL_RESET) * TSQ_W'(TOL_RESET);
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    CFG_LAT_A_FIRST:  lat_a_first_reg  <= cfg_wdata;
                    CFG_LAT_A_SECOND: lat_a_second_reg <= cfg_wdata;
                    CFG_LAT_B_FIRST:  lat_b_first_reg  <= cfg_wdata;
                    CFG_LAT_B_SECOND: lat_b_second_reg <= cfg_wdata;
                    CFG_MATCH_TOL:    tol_reg          <= cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            // tolerance squared is registered from tol_reg and follows it in the next cycle
            tol_sq_reg <= TSQ_W'(tol_reg) * TSQ_W'(tol_reg);
        end
    end

    // ---------------- pipeline control ----------------
    logic               adv;
    logic [N_STAGE-1:0] valid_reg;

    assign adv      = !valid_reg[N_STAGE-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[N_STAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[N_STAGE-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [IDX_W-1:0]  m1, m2, n1, n2;
    logic signed [TRIG_W-1:0] cos_in, sin_in;
    logic signed [LAT_W-1:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

    assign m1     = s_tdata[3:0];
    assign m2     = s_tdata[7:4];
    assign n1     = s_tdata[11:8];
    assign n2     = s_tdata[15:12];
    assign cos_in = s_tdata[33:16];
    assign sin_in = s_tdata[51:34];

    assign ax1 = lat_a_first_reg[63:32];
    assign ay1 = lat_a_first_reg[31:0];
    assign ax2 = lat_a_second_reg[63:32];
    assign ay2 = lat_a_second_reg[31:0];
    assign bx1 = lat_b_first_reg[63:32];
    assign by1 = lat_b_first_reg[31:0];
    assign bx2 = lat_b_second_reg[63:32];
    assign by2 = lat_b_second_reg[31:0];

    // rot_prod: bx1*c, by1*s, bx1*s, by1*c, bx2*c, by2*s, bx2*s, by2*c
    logic signed [ROT_PROD_W-1:0] rot_prod_next [8];
    logic signed [ROT_PROD_W-1:0] rot_prod_reg  [8];
    // a_prod: m1*ax1, m2*ax2, m1*ay1, m2*ay2
    logic signed [A_PROD_W-1:0]   a_prod_next [4];
    logic signed [A_PROD_W-1:0]   a_prod_reg  [4];
    logic signed [IDX_W-1:0]      n1_s1_reg, n2_s1_reg;
    logic                         ok_next;
    logic [N_STAGE-2:0]           ok_reg;

    always_comb begin
        rot_prod_next[0] = bx1 * cos_in;
        rot_prod_next[1] = by1 * sin_in;
        rot_prod_next[2] = bx1 * sin_in;
        rot_prod_next[3] = by1 * cos_in;
        rot_prod_next[4] = bx2 * cos_in;
        rot_prod_next[5] = by2 * sin_in;
        rot_prod_next[6] = bx2 * sin_in;
        rot_prod_next[7] = by2 * cos_in;
        a_prod_next[0]   = m1 * ax1;
        a_prod_next[1]   = m2 * ax2;
        a_prod_next[2]   = m1 * ay1;
        a_prod_next[3]   = m2 * ay2;
        ok_next = index_ok(m1) && index_ok(m2) && index_ok(n1) && index_ok(n2);
    end

    // ok bit travels with the item through stages 1 to 9
    always_ff @(posedge aclk) begin
        if (adv) begin
            rot_prod_reg <= rot_prod_next;
            a_prod_reg   <= a_prod_next;
            n1_s1_reg    <= n1;
            n2_s1_reg    <= n2;
            ok_reg       <= {ok_reg[N_STAGE-3:0], ok_next};
        end
    end

    // ---------------- stage 2: rotate and round, A point ----------------
    logic signed [ROT_W-1:0]     rot_next [4];   // rx1, ry1, rx2, ry2
    logic signed [ROT_W-1:0]     rot_reg  [4];
    logic signed [COORD_W-1:0]   xa_next, ya_next;
    logic signed [COORD_W-1:0]   xa_s2_reg, ya_s2_reg;
    logic signed [IDX_W-1:0]     n1_s2_reg, n2_s2_reg;
    logic signed [ROT_SUM_W-1:0] rsum [4];
    logic signed [ROT_SUM_W-1:0] rbias [4];

    always_comb begin
        rsum[0] = ROT_SUM_W'(rot_prod_reg[0]) + ROT_SUM_W'(rot_prod_reg[1]);
        rsum[1] = ROT_SUM_W'(rot_prod_reg[3]) - ROT_SUM_W'(rot_prod_reg[2]);
        rsum[2] = ROT_SUM_W'(rot_prod_reg[4]) + ROT_SUM_W'(rot_prod_reg[5]);
        rsum[3] = ROT_SUM_W'(rot_prod_reg[7]) - ROT_SUM_W'(rot_prod_reg[6]);
        for (int k = 0; k < 4; k++) begin
            // add half an LSB and floor: ties go towards plus infinity
            rbias[k]    = rsum[k] + ROUND_HALF;
            rot_next[k] = rbias[k][ROT_SUM_W-1:FRAC_W];
        end
        xa_next = COORD_W'(a_prod_reg[0]) + COORD_W'(a_prod_reg[1]);
        ya_next = COORD_W'(a_prod_reg[2]) + COORD_W'(a_prod_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rot_reg   <= rot_next;
            xa_s2_reg <= xa_next;
            ya_s2_reg <= ya_next;
            n1_s2_reg <= n1_s1_reg;
            n2_s2_reg <= n2_s1_reg;
        end
    end

    // ---------------- stage 3: B point ----------------
    logic signed [COORD_W-1:0] xb_next, yb_next;
    logic signed [COORD_W-1:0] xa_s3_reg, ya_s3_reg, xb_reg, yb_reg;

    always_comb begin
        xb_next = COORD_W'(n1_s2_reg) * COORD_W'(rot_reg[0])
                + COORD_W'(n2_s2_reg) * COORD_W'(rot_reg[2]);
        yb_next = COORD_W'(n1_s2_reg) * COORD_W'(rot_reg[1])
                + COORD_W'(n2_s2_reg) * COORD_W'(rot_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xa_s3_reg <= xa_s2_reg;
            ya_s3_reg <= ya_s2_reg;
            xb_reg    <= xb_next;
            yb_reg    <= yb_next;
        end
    end

    // ---------------- stage 4: magnitudes ----------------
    logic [MAG_W-1:0] mag_next [N_MAG];
    logic [MAG_W-1:0] mag_reg  [N_MAG];

    always_comb begin
        mag_next[0] = abs_mag(DIFF_W'(xa_s3_reg));
        mag_next[1] = abs_mag(DIFF_W'(ya_s3_reg));
        mag_next[2] = abs_mag(DIFF_W'(xb_reg));
        mag_next[3] = abs_mag(DIFF_W'(yb_reg));
        mag_next[4] = abs_mag(DIFF_W'(xa_s3_reg) - DIFF_W'(xb_reg));
        mag_next[5] = abs_mag(DIFF_W'(ya_s3_reg) - DIFF_W'(yb_reg));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= mag_next;
        end
    end

    // ---------------- stage 5: square partial products ----------------
    logic [PART_W-1:0] part_lo_next [N_MAG], part_mid_next [N_MAG], part_hi_next [N_MAG];
    logic [PART_W-1:0] part_lo_reg  [N_MAG], part_mid_reg  [N_MAG], part_hi_reg  [N_MAG];

    always_comb begin
        for (int k = 0; k < N_MAG; k++) begin
            part_lo_next[k]  = PART_W'(mag_reg[k][HALF_W-1:0])
                             * PART_W'(mag_reg[k][HALF_W-1:0]);
            part_mid_next[k] = PART_W'(mag_reg[k][MAG_W-1:HALF_W])
                             * PART_W'(mag_reg[k][HALF_W-1:0]);
            part_hi_next[k]  = PART_W'(mag_reg[k][MAG_W-1:HALF_W])
                             * PART_W'(mag_reg[k][MAG_W-1:HALF_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            part_lo_reg  <= part_lo_next;
            part_mid_reg <= part_mid_next;
            part_hi_reg  <= part_hi_next;
        end
    end

    // ---------------- stage 6: combine squares ----------------
    logic [SQ_W-1:0] sq_next [N_MAG];
    logic [SQ_W-1:0] sq_reg  [N_MAG];

    always_comb begin
        for (int k = 0; k < N_MAG; k++) begin
            // cross term counts twice: shift by one more than the half width
            sq_next[k] = {part_hi_reg[k], {MAG_W{1'b0}}}
                       + (SQ_W'(part_mid_reg[k]) << (HALF_W + 1))
                       + SQ_W'(part_lo_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg <= sq_next;
        end
    end

    // ---------------- stage 7: norms and the smaller one ----------------
    logic [NORM_W-1:0] norm_a, norm_b, nmin_next, nmin_reg;
    logic [SQ_W-1:0]   dx2_s7_reg, dy2_s7_reg;

    always_comb begin
        norm_a    = NORM_W'(sq_reg[0]) + NORM_W'(sq_reg[1]);
        norm_b    = NORM_W'(sq_reg[2]) + NORM_W'(sq_reg[3]);
        nmin_next = (norm_b < norm_a) ? norm_b : norm_a;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nmin_reg   <= nmin_next;
            dx2_s7_reg <= sq_reg[4];
            dy2_s7_reg <= sq_reg[5];
        end
    end

    // ---------------- stage 8: scale by tolerance squared, in chunks ----------------
    logic [CPROD_W-1:0] cprod_next [3];
    logic [CPROD_W-1:0] cprod_reg  [3];
    logic [SQ_W-1:0]    dx2_s8_reg, dy2_s8_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cprod_next[k] = CPROD_W'(nmin_reg[k*CHUNK_W +: CHUNK_W]) * CPROD_W'(tol_sq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cprod_reg  <= cprod_next;
            dx2_s8_reg <= dx2_s7_reg;
            dy2_s8_reg <= dy2_s7_reg;
        end
    end

    // ---------------- stage 9: sum the chunks ----------------
    logic [RHS_W-1:0] rhs_next, rhs_reg;
    logic [SQ_W-1:0]  dx2_s9_reg, dy2_s9_reg;

    always_comb begin
        rhs_next = {cprod_reg[2], {(2*CHUNK_W){1'b0}}}
                 + (RHS_W'(cprod_reg[1]) << CHUNK_W)
                 + RHS_W'(cprod_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rhs_reg    <= rhs_next;
            dx2_s9_reg <= dx2_s8_reg;
            dy2_s9_reg <= dy2_s8_reg;
        end
    end

    // ---------------- stage 10: compare ----------------
    logic [RHS_W-1:0] dx_scaled, dy_scaled;
    logic             is_match_next, is_match_reg;

    always_comb begin
        // difference squared is in Q.32; the right side carries tol^2 in Q0.32
        dx_scaled     = {{(RHS_W-SQ_W-TSQ_W){1'b0}}, dx2_s9_reg, {TSQ_W{1'b0}}};
        dy_scaled     = {{(RHS_W-SQ_W-TSQ_W){1'b0}}, dy2_s9_reg, {TSQ_W{1'b0}}};
        is_match_next = ok_reg[N_STAGE-2] && (dx_scaled < rhs_reg) && (dy_scaled < rhs_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            is_match_reg <= is_match_next;
        end
    end

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, is_match_reg};

    // ---------------- assertions ----------------
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_advance_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> valid_reg[N_STAGE-1] == $past(valid_reg[N_STAGE-2]))
        else $error("item lost or repeated at the output stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    a_stall_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input item taken while the pipeline holds");

endmodule

`default_nettype wire
